@@ hdl/utf_dec_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants of the UTF-8 to UTF-16 lenient decoder.
package utf_dec_pkg;

   // Request payload: one UTF-8 byte and the end-of-string flag.
   typedef struct packed {
      logic [7:0] in_byte;
      logic       is_final;
   } req_type;

   // Result payload: one UTF-16 code unit with its framing flags.
   typedef struct packed {
      logic [15:0] code_unit;
      logic        run_last;
      logic        string_done;
   } rsp_type;

   // Byte class, worked out once when the byte enters the block.
   typedef struct packed {
      logic       ascii;
      logic       bad_lead;
      logic [1:0] need;
      logic       cont;
   } byte_class_type;

   typedef struct packed {
      logic [7:0]     value;
      byte_class_type cls;
   } held_byte_type;

   typedef struct packed {
      held_byte_type hb;
      logic          is_final;
   } queue_entry_type;

   // Head of the request queue as seen by the decode side.
   typedef struct packed {
      logic            valid;
      queue_entry_type entry;
   } queue_head_type;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
   localparam int HOLD_DEPTH  = 4;

   localparam logic [2:0]  MAX_RESULTS    = 3'd4;
   localparam logic [15:0] REPL_UNIT      = 16'hFFFD;
   localparam logic [15:0] HIGH_SURR_BASE = 16'hD800;
   localparam logic [15:0] LOW_SURR_BASE  = 16'hDC00;
   localparam logic [10:0] MIN_TWO_BYTE   = 11'h080;
   localparam logic [15:0] MIN_THREE_BYTE = 16'h0800;
   localparam logic [15:0] SURR_FIRST     = 16'hD800;
   localparam logic [15:0] SURR_LAST      = 16'hDFFF;
   localparam logic [20:0] MIN_FOUR_BYTE  = 21'h010000;
   localparam logic [20:0] MAX_CODE_POINT = 21'h10FFFF;

endpackage

@@ hdl/utf_dec_front.sv @@
`timescale 1ns / 1ps
// Front end: classifies incoming bytes and queues them for the decode side.
module utf_dec_front (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  utf_dec_pkg::req_type        req_data,
   output utf_dec_pkg::queue_head_type head,
   input  logic                        pop
);

   utf_dec_pkg::queue_entry_type      q_ff [utf_dec_pkg::QUEUE_DEPTH];
   logic [utf_dec_pkg::QPTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [utf_dec_pkg::QPTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [utf_dec_pkg::QCNT_W-1:0]    count_ff, count_in;
   utf_dec_pkg::queue_entry_type      new_entry;
   logic                              push;
   logic                              do_pop;

   localparam logic [utf_dec_pkg::QPTR_W-1:0] LAST_PTR =
      utf_dec_pkg::QPTR_W'(utf_dec_pkg::QUEUE_DEPTH - 1);
   localparam logic [utf_dec_pkg::QCNT_W-1:0] FULL_COUNT =
      utf_dec_pkg::QCNT_W'(utf_dec_pkg::QUEUE_DEPTH);

   function automatic utf_dec_pkg::byte_class_type classify(input logic [7:0] b);
      utf_dec_pkg::byte_class_type c;
      logic lead2, lead3, lead4;
      lead2      = (b[7:5] == 3'b110);
      lead3      = (b[7:4] == 4'b1110);
      lead4      = (b[7:3] == 5'b11110);
      c.ascii    = ~b[7];
      c.cont     = (b[7:6] == 2'b10);
      c.bad_lead = b[7] & ~lead2 & ~lead3 & ~lead4;
      c.need     = lead2 ? 2'd1 : lead3 ? 2'd2 : lead4 ? 2'd3 : 2'd0;
      return c;
   endfunction

   assign req_ready = (count_ff != FULL_COUNT);
   assign push      = req_valid && req_ready;
   assign do_pop    = pop && (count_ff != '0);

   always_comb begin
      new_entry.hb.value = req_data.in_byte;
      new_entry.hb.cls   = classify(req_data.in_byte);
      new_entry.is_final = req_data.is_final;
      head.valid         = (count_ff != '0);
      head.entry         = q_ff[rd_ptr_ff];
      wr_ptr_in          = wr_ptr_ff;
      rd_ptr_in          = rd_ptr_ff;
      count_in           = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= new_entry;
      end
   end

endmodule

@@ hdl/utf_dec_back.sv @@
`timescale 1ns / 1ps
// Back: holds pending bytes, one sequence per unstalled cycle, drives results.
module utf_dec_back (
   input  logic                        clock,
   input  logic                        reset,
   input  utf_dec_pkg::queue_head_type head,
   output logic                        pop,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output utf_dec_pkg::rsp_type        rsp_data
);

   utf_dec_pkg::held_byte_type hold_ff [utf_dec_pkg::HOLD_DEPTH];
   logic [2:0]                 cnt_ff;
   logic                       fin_ff;
   logic [2:0]                 n_ff;
   logic                       pair_ff;
   logic [15:0]                low_ff;
   logic                       active_ff;
   logic                       rsp_valid_ff, rsp_valid_in;
   utf_dec_pkg::rsp_type       rsp_data_ff, rsp_data_in;

   utf_dec_pkg::held_byte_type work [utf_dec_pkg::HOLD_DEPTH];
   utf_dec_pkg::held_byte_type hold_in [utf_dec_pkg::HOLD_DEPTH];
   logic [2:0]                 work_cnt, cnt_in;
   logic                       work_fin;
   logic [2:0]                 work_n, n_in;
   logic                       work_pair, pair_in;
   logic [15:0]                low_in;
   logic                       more;
   logic                       act, emit, last;
   logic [15:0]                unit;
   logic [2:0]                 consume;
   logic                       clear_all;
   logic                       conts_ok;
   logic [10:0]                cp2;
   logic [15:0]                cp3;
   logic [20:0]                cp4;
   logic [19:0]                offset;
   logic [2:0]                 idx;
   logic                       out_free, step;

   function automatic logic can_decide(input utf_dec_pkg::byte_class_type c,
                                       input logic [2:0] count);
      return (count != 3'd0) && (c.ascii || c.bad_lead || (count > {1'b0, c.need}));
   endfunction

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign step     = (active_ff || head.valid) && out_free;
   assign pop      = step && !active_ff;

   always_comb begin
      // Work view: the held bytes, plus the queue head when a new byte starts.
      work      = hold_ff;
      work_cnt  = cnt_ff;
      work_fin  = fin_ff;
      work_n    = n_ff;
      work_pair = pair_ff;
      if (!active_ff) begin
         work[cnt_ff[1:0]] = head.entry.hb;
         work_cnt  = cnt_ff + 3'd1;
         work_fin  = head.entry.is_final;
         work_n    = 3'd0;
         work_pair = 1'b0;
      end

      conts_ok = work[1].cls.cont
               && ((work[0].cls.need < 2'd2) || work[2].cls.cont)
               && ((work[0].cls.need < 2'd3) || work[3].cls.cont);
      cp2    = {work[0].value[4:0], work[1].value[5:0]};
      cp3    = {work[0].value[3:0], work[1].value[5:0], work[2].value[5:0]};
      cp4    = {work[0].value[2:0], work[1].value[5:0], work[2].value[5:0],
                work[3].value[5:0]};
      offset = 20'(cp4 - utf_dec_pkg::MIN_FOUR_BYTE);

      act       = 1'b0;
      unit      = utf_dec_pkg::REPL_UNIT;
      consume   = 3'd0;
      clear_all = 1'b0;
      pair_in   = 1'b0;
      low_in    = low_ff;

      if (work_pair) begin
         act  = 1'b1;
         unit = low_ff;
      end else if (can_decide(work[0].cls, work_cnt)) begin
         act     = 1'b1;
         consume = 3'd1;
         if (work[0].cls.ascii) begin
            unit = {8'd0, work[0].value};
         end else if (work[0].cls.bad_lead || !conts_ok) begin
            unit = utf_dec_pkg::REPL_UNIT;
         end else begin
            case (work[0].cls.need)
               2'd1: begin
                  consume = 3'd2;
                  unit    = (cp2 < utf_dec_pkg::MIN_TWO_BYTE) ? utf_dec_pkg::REPL_UNIT
                                                              : {5'd0, cp2};
               end
               2'd2: begin
                  consume = 3'd3;
                  if (cp3 < utf_dec_pkg::MIN_THREE_BYTE ||
                      (cp3 >= utf_dec_pkg::SURR_FIRST && cp3 <= utf_dec_pkg::SURR_LAST)) begin
                     unit = utf_dec_pkg::REPL_UNIT;
                  end else begin
                     unit = cp3;
                  end
               end
               default: begin
                  consume = 3'd4;
                  if (cp4 < utf_dec_pkg::MIN_FOUR_BYTE ||
                      cp4 > utf_dec_pkg::MAX_CODE_POINT) begin
                     unit = utf_dec_pkg::REPL_UNIT;
                  end else begin
                     unit    = 16'(utf_dec_pkg::HIGH_SURR_BASE + {6'd0, offset[19:10]});
                     pair_in = 1'b1;
                     low_in  = 16'(utf_dec_pkg::LOW_SURR_BASE + {6'd0, offset[9:0]});
                  end
               end
            endcase
         end
      end else if (work_fin && work_cnt != 3'd0) begin
         // String ended inside a sequence: one replacement, drop the rest.
         act       = 1'b1;
         clear_all = 1'b1;
      end

      for (int j = 0; j < utf_dec_pkg::HOLD_DEPTH; j++) begin
         idx        = 3'(j) + consume;
         hold_in[j] = work[j];
         if (idx < 3'(utf_dec_pkg::HOLD_DEPTH)) begin
            hold_in[j] = work[idx[1:0]];
         end
      end
      cnt_in = clear_all ? 3'd0 : work_cnt - consume;

      more = pair_in || can_decide(hold_in[0].cls, cnt_in) || (work_fin && cnt_in != 3'd0);
      emit = act && (work_n < utf_dec_pkg::MAX_RESULTS);
      n_in = work_n + 3'(emit);
      last = emit && (!more || n_in == utf_dec_pkg::MAX_RESULTS);

      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      if (step && emit) begin
         rsp_valid_in            = 1'b1;
         rsp_data_in.code_unit   = unit;
         rsp_data_in.run_last    = last;
         rsp_data_in.string_done = last && work_fin;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= 3'd0;
         n_ff         <= 3'd0;
         pair_ff      <= 1'b0;
         active_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (step) begin
            cnt_ff    <= cnt_in;
            n_ff      <= n_in;
            pair_ff   <= pair_in;
            active_ff <= more;
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      if (step) begin
         hold_ff <= hold_in;
         fin_ff  <= work_fin;
         low_ff  <= low_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

@@ hdl/utf8_to_utf16_lenient_decoder_top.sv @@
`timescale 1ns / 1ps
// Top level of the UTF-8 to UTF-16 lenient decoder.
//
// Usage: bytes of a UTF-8 string arrive on the req_ channel (valid/ready),
// one byte per request, with is_final set on the string's last byte. UTF-16
// code units leave on the rsp_ channel; run_last marks the last unit caused
// by a request and string_done the final unit of the string. Malformed input
// is replaced by U+FFFD, and a supplementary code point leaves as a surrogate
// pair on two consecutive responses.
// Throughput: the decode side takes at most one request and emits at most one
// response per cycle while the response register can take a unit; a request
// that yields several units (up to four) keeps it busy until they have left.
// The response register is the limit: it takes one unit per cycle.
// Path: an accepted request is written into the request queue; the decode
// side reads it at the queue head and registers the unit in rsp_data.
// Reset (synchronous, active high) empties the request queue, the held bytes
// and the response register. When the receiver holds rsp_ready low, the
// two-entry request queue keeps accepting until it is full, then req_ready
// drops; nothing is lost or reordered.
module utf8_to_utf16_lenient_decoder_top (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  utf_dec_pkg::req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output utf_dec_pkg::rsp_type rsp_data
);

   // Queue head handed from the front end to the decode side.
   utf_dec_pkg::queue_head_type head;
   logic                        pop;

   // The front end classifies each byte on entry so that the decode side
   // only compares stored class bits when it picks a rule.
   utf_dec_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .head      (head),
      .pop       (pop)
   );

   // The decode side holds up to four bytes, resolves one rule per cycle while
   // the response register is free, and owns the response register.
   utf_dec_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (head),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule
